// ===== sv/ct_pkg.sv =====
// Shared constants and types for the columnar transposition block.
`default_nettype none

package ct_pkg;

	// Field and register widths
	localparam int BYTE_W = 8;
	localparam int COL_W  = 7;
	localparam int IDX_W  = 1;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_COLUMNS = 1'b0;
	localparam logic [IDX_W-1:0] REG_DECODE  = 1'b1;

	// Reset values and defaults
	localparam logic [COL_W-1:0] COLUMNS_RESET = 7'd1;
	localparam int               DEPTH_DEFAULT = 64;

	typedef logic [BYTE_W-1:0] byte_t;

endpackage

`default_nettype wire

// ===== sv/ct_if.sv =====
// Valid/ready stream interfaces for the load and emit channels.
`default_nettype none

interface ct_load_if import ct_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ct_emit_if import ct_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t out_byte;
	logic  out_last;

	modport source (output valid, output out_byte, output out_last, input ready);
	modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

// ===== sv/ct_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ct_ram #(
	parameter  int WIDTH = 8,
	parameter  int DEPTH = 64,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds when re is low
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/ct_div.sv =====
// Serial restoring divider: block length by column count, one quotient bit per cycle.
`default_nettype none

module ct_div import ct_pkg::*; #(
	parameter int NW = 7
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NW-1:0]    dividend,
	input  wire logic [COL_W-1:0] divisor,
	output logic                  done,
	output logic      [NW-1:0]    quot,
	output logic      [COL_W-1:0] rem
);

	localparam int CNT_W = (NW > 1) ? $clog2(NW) : 1;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    quot_q;
	logic [COL_W-1:0] rem_q;

	logic [COL_W:0]   rem_sh;
	logic [COL_W:0]   rem_sub;
	logic             fits;

	// One restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		rem_sh  = {rem_q, quot_q[NW-1]};
		fits    = (rem_sh >= {1'b0, divisor});
		rem_sub = fits ? (rem_sh - {1'b0, divisor}) : rem_sh;
	end

	// Step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
		end
	end

	// Quotient shifts in from the dividend register
	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			quot_q <= {quot_q[NW-2:0], fits};
			rem_q  <= rem_sub[COL_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

// ===== sv/columnar_transposition.sv =====
// Top level of the columnar transposition block: load buffer, divider and read sequencer.
// Bytes on the load channel are written one per cycle, while load ready is high, into a block
// RAM. The byte flagged last, or the one that fills the last of BLOCK_DEPTH slots, closes the
// block; the column count and mode in effect at that moment are latched. A serial divider
// then splits the block length L into rows and remainder, with LW = clog2(BLOCK_DEPTH+1)
// quotient bits. Emission follows at one byte per cycle, set by the single RAM read port
// whose registered data is the output stage, and it stalls only on emit.ready. Load ready
// is low from the closing transfer until the last read of the block has been issued; the
// next block may load while the final byte still waits on emit. A column count of zero
// acts as one column. Register writes take effect on the next block.
`default_nettype none

module columnar_transposition import ct_pkg::*; #(
	parameter int BLOCK_DEPTH = DEPTH_DEFAULT
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	ct_load_if.sink               load,
	ct_emit_if.source             emit,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_index,
	input  wire logic [COL_W-1:0] wr_data
);

	localparam int AW = $clog2(BLOCK_DEPTH);
	localparam int LW = $clog2(BLOCK_DEPTH + 1);
	localparam int CW = (LW > COL_W) ? LW : COL_W;
	localparam int SW = CW + 1;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]       state_q;
	logic [COL_W-1:0] columns_q;
	logic             decode_q;
	logic [LW-1:0]    fill_q;
	logic [LW-1:0]    len_q;
	logic [COL_W-1:0] c_q;
	logic             dec_q;
	logic [LW-1:0]    k_q;
	logic [CW-1:0]    col_q;
	logic [LW-1:0]    row_q;
	logic [LW-1:0]    addr_q;
	logic             ov_q;
	logic             last_q;

	logic             load_xfer;
	logic [LW-1:0]    fill_nx;
	logic             close;
	logic             issue;
	logic             k_last;
	logic             div_done;
	logic [LW-1:0]    quot;
	logic [COL_W-1:0] rem;
	byte_t            rdata;

	logic [SW-1:0]    addr_w, c_w, len_w, col_w, row_w, q_w, r_w;
	logic [SW-1:0]    enc_sum;
	logic [SW-1:0]    addr_nx_w;
	logic [SW-1:0]    col_nx_w;
	logic [SW-1:0]    row_nx_w;

	// Load side
	assign load.ready = (state_q == ST_LOAD);
	assign load_xfer  = load.valid && load.ready;
	assign fill_nx    = fill_q + LW'(1);
	assign close      = load_xfer && (load.last_byte || (fill_nx == LW'(BLOCK_DEPTH)));

	// Read issue: the RAM data register is the output stage
	assign issue  = (state_q == ST_EMIT) && (!ov_q || emit.ready);
	assign k_last = ((k_q + LW'(1)) == len_q);

	// Next read address for both permutations
	always_comb begin
		addr_w  = SW'(addr_q);
		c_w     = SW'(c_q);
		len_w   = SW'(len_q);
		col_w   = SW'(col_q);
		row_w   = SW'(row_q);
		q_w     = SW'(quot);
		r_w     = SW'(rem);
		enc_sum = addr_w + c_w;
		row_nx_w  = row_w;
		col_nx_w  = col_w;
		addr_nx_w = addr_w;
		if (!dec_q) begin
			// encode: step down a column, then move to the next column start
			if (enc_sum < len_w) begin
				addr_nx_w = enc_sum;
			end else begin
				col_nx_w  = col_w + SW'(1);
				addr_nx_w = col_w + SW'(1);
			end
		end else begin
			// decode: hop across column starts, the first r columns one longer
			if ((col_w + SW'(1)) == c_w) begin
				col_nx_w  = '0;
				row_nx_w  = row_w + SW'(1);
				addr_nx_w = row_w + SW'(1);
			end else begin
				col_nx_w  = col_w + SW'(1);
				addr_nx_w = addr_w + ((col_w < r_w) ? (q_w + SW'(1)) : q_w);
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q <= COLUMNS_RESET;
			decode_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_COLUMNS: columns_q <= wr_data;
				REG_DECODE:  decode_q  <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer: load, divide, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			fill_q  <= '0;
			len_q   <= '0;
			c_q     <= COLUMNS_RESET;
			dec_q   <= 1'b0;
			k_q     <= '0;
			col_q   <= '0;
			row_q   <= '0;
			addr_q  <= '0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (close) begin
						fill_q  <= '0;
						len_q   <= fill_nx;
						c_q     <= (columns_q == '0) ? COL_W'(1) : columns_q;
						dec_q   <= decode_q;
						state_q <= ST_DIV;
					end else if (load_xfer) begin
						fill_q <= fill_nx;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						k_q     <= '0;
						col_q   <= '0;
						row_q   <= '0;
						addr_q  <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (issue) begin
						k_q    <= k_q + LW'(1);
						col_q  <= col_nx_w[CW-1:0];
						row_q  <= row_nx_w[LW-1:0];
						addr_q <= addr_nx_w[LW-1:0];
						if (k_last) begin
							state_q <= ST_LOAD;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (issue) begin
			ov_q <= 1'b1;
		end else if (emit.ready) begin
			ov_q <= 1'b0;
		end
	end

	// Last flag travels with the read data
	always_ff @(posedge clk) begin
		if (issue) begin
			last_q <= k_last;
		end
	end

	ct_div #(
		.NW(LW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (close),
		.dividend (fill_nx),
		.divisor  (c_q),
		.done     (div_done),
		.quot     (quot),
		.rem      (rem)
	);

	ct_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(BLOCK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (load_xfer),
		.waddr (fill_q[AW-1:0]),
		.wdata (load.data_byte),
		.re    (issue),
		.raddr (addr_q[AW-1:0]),
		.rdata (rdata)
	);

	assign emit.valid    = ov_q;
	assign emit.out_byte = rdata;
	assign emit.out_last = last_q;

`ifndef SYNTHESIS
	// Emission never runs past the block length
	a_count_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (k_q < len_q))
		else $error("emit count beyond block length");

	// Every read lands inside the current block
	a_addr_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (addr_q < len_q))
		else $error("read address outside block");

	// Fill pointer stays inside the buffer
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q < LW'(BLOCK_DEPTH))
		else $error("fill count reached buffer depth");

	// A stalled output byte holds until its transfer
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(emit.valid && !emit.ready) |=>
		(emit.valid && $stable(emit.out_byte) && $stable(emit.out_last)))
		else $error("output changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for columnar_transposition: random bursts in, predicted permuted blocks checked out.
`timescale 1ns / 1ps

module tb;
	import ct_pkg::*;

	localparam int DEPTH    = 64;
	localparam int SETTLE   = 20;       // divider plus handover, with margin
	localparam int N_ITEMS  = 320;

	typedef struct packed {
		byte_t data;
		logic  last;
	} load_item_t;

	typedef struct packed {
		byte_t out_byte;
		logic  out_last;
	} emit_item_t;

	logic             clk;
	logic             arst_n;
	logic             wr_en;
	logic [IDX_W-1:0] wr_index;
	logic [COL_W-1:0] wr_data;

	ct_load_if load_ch ();
	ct_emit_if emit_ch ();

	columnar_transposition #(
		.BLOCK_DEPTH(DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load_ch),
		.emit     (emit_ch),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	// Stimulus and expectation stores
	load_item_t pending_bytes[$];
	emit_item_t expected_out[$];
	int         bytes_queued;
	int         bytes_loaded;
	int         results_seen;
	int         mismatches;

	// Predictor state: block buffer and the configuration it will close with
	byte_t            blk_buf[DEPTH];
	int               blk_fill;
	logic [COL_W-1:0] cfg_columns;
	logic             cfg_decode;

	// Sender burst and receiver stall state
	int         burst_left;
	int         gap_left;
	logic [7:0] stall_pat;
	int         pat_left;

	// Clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Append one predicted result
	task automatic expect_result(input byte_t b, input logic l);
		emit_item_t e;
		e.out_byte = b;
		e.out_last = l;
		expected_out.insert(expected_out.size(), e);
	endtask

	// Append the permuted block to the expected results and empty the buffer
	task automatic close_block();
		int len, c, q, r, k, col, row, i, col_len, start;
		len = blk_fill;
		c = (cfg_columns == '0) ? 1 : int'(cfg_columns);
		k = 0;
		if (!cfg_decode) begin
			// write by rows, read by columns
			for (col = 0; col < c && col < len; col++) begin
				for (i = col; i < len; i += c) begin
					expect_result(blk_buf[i], (k == len - 1));
					k++;
				end
			end
		end else begin
			// first r columns are one longer; read them back row by row
			q = len / c;
			r = len % c;
			for (row = 0; row <= q; row++) begin
				for (col = 0; col < c; col++) begin
					col_len = (col < r) ? q + 1 : q;
					if (row < col_len) begin
						start = (col < r) ? col * (q + 1) : r * (q + 1) + (col - r) * q;
						expect_result(blk_buf[start + row], (k == len - 1));
						k++;
					end
				end
			end
		end
		blk_fill = 0;
	endtask

	// Load driver: bursts of random length separated by random gaps
	always @(posedge clk) begin
		if (!arst_n) begin
			load_ch.valid <= 1'b0;
		end else if (!load_ch.valid || load_ch.ready) begin
			if (gap_left > 0 || pending_bytes.size() == 0) begin
				load_ch.valid <= 1'b0;
				if (gap_left > 0)
					gap_left <= gap_left - 1;
			end else begin
				load_ch.valid     <= 1'b1;
				load_ch.data_byte <= pending_bytes[0].data;
				load_ch.last_byte <= pending_bytes[0].last;
				void'(pending_bytes.pop_front());
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	// Emit ready: rotating stall pattern, reloaded when pat_left runs out, never all zero
	always @(posedge clk) begin
		if (!arst_n) begin
			emit_ch.ready <= 1'b0;
		end else begin
			emit_ch.ready <= stall_pat[0];
			if (pat_left == 0) begin
				stall_pat <= ($urandom_range(0, 3) == 0) ? 8'hFF :
					(8'($urandom) | (8'h01 << $urandom_range(0, 7)));
				pat_left  <= 31;
			end else begin
				stall_pat <= {stall_pat[0], stall_pat[7:1]};
				pat_left  <= pat_left - 1;
			end
		end
	end

	// Monitor: check emitted bytes, then feed accepted load bytes to the predictor
	always @(posedge clk) begin
		if (arst_n) begin
			if (emit_ch.valid && emit_ch.ready) begin
				if (expected_out.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("tb: result %0d unexpected: out_byte %h out_last %b",
							results_seen, emit_ch.out_byte, emit_ch.out_last);
				end else begin
					if (emit_ch.out_byte !== expected_out[0].out_byte ||
					    emit_ch.out_last !== expected_out[0].out_last) begin
						mismatches++;
						if (mismatches <= 10)
							$display("tb: result %0d: out_byte exp %h got %h, out_last exp %b got %b",
								results_seen, expected_out[0].out_byte, emit_ch.out_byte,
								expected_out[0].out_last, emit_ch.out_last);
					end
					void'(expected_out.pop_front());
				end
				results_seen++;
			end
			if (load_ch.valid && load_ch.ready) begin
				if (blk_fill >= DEPTH)
					blk_fill = 0;
				blk_buf[blk_fill] = load_ch.data_byte;
				blk_fill++;
				bytes_loaded++;
				if (load_ch.last_byte || blk_fill >= DEPTH)
					close_block();
			end
		end
	end

	// Queue one load transfer
	task automatic push_byte(input byte_t b, input logic last);
		load_item_t item;
		item.data = b;
		item.last = last;
		pending_bytes.insert(pending_bytes.size(), item);
		bytes_queued++;
	endtask

	// Queue a block of random bytes; past DEPTH bytes the buffer closes it on its own
	task automatic push_block(input int len, input bit flag_end);
		int i;
		for (i = 0; i < len; i++)
			push_byte(byte_t'($urandom), flag_end && (i == len - 1));
	endtask

	// Wait until every byte is loaded and every result has come, then let the block settle
	task automatic drain();
		while (!(bytes_loaded == bytes_queued && expected_out.size() == 0))
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write both registers while idle
	task automatic set_config(input logic [COL_W-1:0] cols, input logic dec);
		cfg_columns = cols;
		cfg_decode  = dec;
		@(posedge clk);
		wr_en    <= 1'b1;
		wr_index <= REG_COLUMNS;
		wr_data  <= cols;
		@(posedge clk);
		wr_index <= REG_DECODE;
		wr_data  <= COL_W'(dec);
		@(posedge clk);
		wr_en    <= 1'b0;
	endtask

	// Random column count, weighted toward small tables with the extremes mixed in
	function automatic logic [COL_W-1:0] pick_columns();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel)
			0: return '0;
			1: return COL_W'(64);
			2: return '1;
			3: return COL_W'($urandom_range(65, 126));
			default: return COL_W'($urandom_range(1, 12));
		endcase
	endfunction

	// Main sequence
	initial begin
		int nblk, b, sel;
		clk               = 1'b0;
		arst_n            = 1'b0;
		wr_en             = 1'b0;
		wr_index          = REG_COLUMNS;
		wr_data           = '0;
		load_ch.valid     = 1'b0;
		load_ch.data_byte = '0;
		load_ch.last_byte = 1'b0;
		emit_ch.ready     = 1'b0;
		bytes_queued      = 0;
		bytes_loaded      = 0;
		results_seen      = 0;
		mismatches        = 0;
		blk_fill          = 0;
		cfg_columns       = COLUMNS_RESET;
		cfg_decode        = 1'b0;
		burst_left        = 8;
		gap_left          = 0;
		stall_pat         = 8'hFF;
		pat_left          = 31;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Reset configuration: one column, encode; single-byte block and byte extremes
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h5A, 1'b1);
		drain();

		// Uneven table both ways: 7 bytes over 3 columns
		set_config(COL_W'(3), 1'b0);
		push_block(7, 1'b1);
		drain();
		set_config(COL_W'(3), 1'b1);
		push_block(7, 1'b1);
		drain();

		// Zero columns acts as one
		set_config('0, 1'b1);
		push_block(2, 1'b1);
		drain();

		// More columns than bytes
		set_config('1, 1'b0);
		push_block(4, 1'b1);
		drain();

		// Full buffer closes the block with no last flag, then a short block follows
		set_config(COL_W'(64), 1'b1);
		push_block(DEPTH, 1'b0);
		push_block(5, 1'b1);
		drain();

		// Random phases: new settings, then a few blocks
		while (bytes_queued < N_ITEMS) begin
			set_config(pick_columns(), 1'($urandom_range(0, 1)));
			nblk = $urandom_range(1, 4);
			for (b = 0; b < nblk && bytes_queued < N_ITEMS; b++) begin
				sel = $urandom_range(0, 9);
				if (sel == 0)
					push_block(DEPTH, 1'($urandom_range(0, 1)));
				else if (sel == 1)
					push_block($urandom_range(DEPTH + 1, DEPTH + 26), 1'b1);
				else
					push_block($urandom_range(1, 24), 1'b1);
			end
			drain();
		end

		if (mismatches == 0 && expected_out.size() == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

	// Run limit
	initial begin
		#2_000_000;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/ct_pkg.sv
sv/ct_if.sv
sv/ct_ram.sv
sv/ct_div.sv
sv/columnar_transposition.sv
test/tb.sv
